>>> design/baro_temp_pressure_compensation_defines.svh
// Assertion macros used by the compensation block's pipeline control.
// Each macro expects clk_i, and BPTC_ASSERT also rst_ni, in the scope where it is used.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_DEFINES_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_DEFINES_SVH

// Checked on every rising clock edge while out of reset.
`define BPTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising clock edge, reset included.
`define BPTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

>>> design/bptc_pkg.sv
// Package of the barometric compensation block: payload structs, register
// indexes, pipeline constants and the output saturation helper. No dependencies.
package bptc_pkg;

  localparam int unsigned NumStages = 5;
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned CoefW     = 16;

  // Reciprocal of five scaled by 2^24, rounded up. Exact for dividends below 2^22.
  localparam int unsigned RecipShift = 24;
  localparam logic [21:0] Recip5     = 22'd3355444;
  localparam logic signed [15:0] FahrOffset = 16'sd3200;
  localparam logic [7:0]  CentiScale = 8'd100;

  typedef enum logic [CfgIdxW-1:0] {
    RegTGain   = 4'd0,
    RegTOffset = 4'd1,
    RegSConst  = 4'd2,
    RegSLinear = 4'd3,
    RegSSquare = 4'd4,
    RegOConst  = 4'd5,
    RegOLinear = 4'd6,
    RegOSquare = 4'd7
  } bptc_reg_e;

  typedef struct packed {
    logic        [CoefW-1:0] t_gain;
    logic        [CoefW-1:0] t_offset;
    logic        [CoefW-1:0] s_const;
    logic        [CoefW-1:0] s_linear;
    logic signed [CoefW-1:0] s_square;
    logic signed [CoefW-1:0] o_const;
    logic signed [CoefW-1:0] o_linear;
    logic signed [CoefW-1:0] o_square;
  } bptc_coef_t;

  typedef struct packed {
    logic signed [15:0] raw_temp;
    logic        [15:0] raw_press;
    logic               want_fahrenheit;
  } bptc_in_t;

  typedef struct packed {
    logic signed [15:0] temp_hundredths;
    logic signed [31:0] pressure_pa;
  } bptc_out_t;

  // Load enables, one per pipeline stage.
  typedef struct packed {
    logic [NumStages-1:0] en;
  } bptc_ctrl_t;

  // Clamp a signed 22-bit pressure to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [21:0] v);
    logic signed [31:0] ext;
    ext = 32'(v);
    if (ext > 32'sh7FFF_FFFF) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (ext < -32'sh7FFF_FFFF - 32'sd1) begin
      sat32 = -32'sh7FFF_FFFF - 32'sd1;
    end else begin
      sat32 = ext;
    end
  endfunction

endpackage

>>> design/bptc_cfg_regs.sv
// Calibration coefficient registers written over the configuration channel.
// Depends on bptc_pkg.
module bptc_cfg_regs
  import bptc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CoefW-1:0]   cfg_data_i,
  output bptc_coef_t         coef_o
);

  bptc_coef_t coef_q, coef_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    coef_d = coef_q;
    if (cfg_valid_i) begin
      case (bptc_reg_e'(cfg_index_i))
        RegTGain:   coef_d.t_gain   = cfg_data_i;
        RegTOffset: coef_d.t_offset = cfg_data_i;
        RegSConst:  coef_d.s_const  = cfg_data_i;
        RegSLinear: coef_d.s_linear = cfg_data_i;
        RegSSquare: coef_d.s_square = cfg_data_i;
        RegOConst:  coef_d.o_const  = cfg_data_i;
        RegOLinear: coef_d.o_linear = cfg_data_i;
        RegOSquare: coef_d.o_square = cfg_data_i;
        default:    coef_d = coef_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

>>> design/bptc_pipe_ctrl.sv
// Valid chain and per-stage load enables of the compensation pipeline.
// Depends on bptc_pkg and the assertion macro header.
`include "baro_temp_pressure_compensation_defines.svh"

module bptc_pipe_ctrl
  import bptc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output bptc_ctrl_t ctrl_o
);

  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages:0]   ready;
  logic [NumStages-1:0] upstream;

  // A stage may load when it is empty or its content moves on this cycle.
  always_comb begin
    ready[NumStages] = out_ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
    upstream = {valid_q[NumStages-2:0], in_valid_i};
    for (int k = 0; k < NumStages; k++) begin
      ctrl_o.en[k] = ready[k];
      valid_d[k]   = ready[k] ? upstream[k] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[NumStages-1];

  `BPTC_ASSERT(a_empty_first_ready, !valid_q[0] |-> in_ready_o,
               "first stage empty but input not ready")
  `BPTC_ASSERT(a_first_held, valid_q[0] && !ctrl_o.en[1] |=> valid_q[0],
               "first stage item lost while next stage stalled")
  `BPTC_ASSERT(a_bubble, ctrl_o.en[0] && !in_valid_i |=> !valid_q[0],
               "first stage filled without an input transfer")
  `BPTC_ASSERT(a_out_fill, ctrl_o.en[NumStages-1] && valid_q[NumStages-2] |=> out_valid_o,
               "item did not reach the output register")

endmodule

>>> design/bptc_temp_path.sv
// Temperature datapath: linear compensation and the optional Fahrenheit
// conversion over five stages. Depends on bptc_pkg.
module bptc_temp_path
  import bptc_pkg::*;
(
  input  logic               clk_i,
  input  bptc_ctrl_t         ctrl_i,
  input  bptc_coef_t         coef_i,
  input  logic signed [15:0] raw_temp_i,
  input  logic               fahr_i,
  output logic signed [15:0] temp_o
);

  // Stage 1: gain times raw temperature, shifted down by eight.
  logic signed [32:0] gain_prod;
  logic signed [24:0] g_q;
  logic               fahr1_q;
  assign gain_prod = $signed({1'b0, coef_i.t_gain}) * raw_temp_i;

  // Stage 2: add the offset, scale to hundredths.
  logic signed [25:0] base_sum;
  logic signed [33:0] centi_prod;
  logic signed [16:0] c2_q;
  logic               fahr2_q;
  assign base_sum   = 26'(g_q) + $signed({4'b0, coef_i.t_offset, 6'b0});
  assign centi_prod = 34'(base_sum) * $signed({1'b0, CentiScale});

  // Stage 3: times nine, then divide the magnitude by five by reciprocal.
  logic signed [20:0] c9;
  logic signed [20:0] c9_neg;
  logic        [19:0] mag;
  logic        [41:0] div_prod;
  logic        [17:0] q3_q;
  logic               neg3_q;
  logic signed [16:0] c3_q;
  logic               fahr3_q;
  assign c9       = (21'(c2_q) <<< 3) + 21'(c2_q);
  assign c9_neg   = -c9;
  assign mag      = c9[20] ? c9_neg[19:0] : c9[19:0];
  assign div_prod = 42'(mag) * 42'(Recip5);

  // Stage 4: restore the sign and pick the unit.
  logic signed [18:0] q_signed;
  logic signed [15:0] temp_d;
  logic signed [15:0] t4_q;
  logic signed [15:0] t5_q;
  assign q_signed = neg3_q ? -$signed({1'b0, q3_q}) : $signed({1'b0, q3_q});
  assign temp_d   = fahr3_q ? (q_signed[15:0] + FahrOffset) : c3_q[15:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      g_q     <= gain_prod[32:8];
      fahr1_q <= fahr_i;
    end
    if (ctrl_i.en[1]) begin
      c2_q    <= centi_prod[32:16];
      fahr2_q <= fahr1_q;
    end
    if (ctrl_i.en[2]) begin
      q3_q    <= div_prod[RecipShift+17:RecipShift];
      neg3_q  <= c9[20];
      c3_q    <= c2_q;
      fahr3_q <= fahr2_q;
    end
    if (ctrl_i.en[3]) begin
      t4_q <= temp_d;
    end
    if (ctrl_i.en[4]) begin
      t5_q <= t4_q;
    end
  end

  assign temp_o = t5_q;

endmodule

>>> design/bptc_press_path.sv
// Pressure datapath: quadratic sensitivity and offset terms, the wide
// sensitivity product and saturation, over five stages. Depends on bptc_pkg.
module bptc_press_path
  import bptc_pkg::*;
(
  input  logic               clk_i,
  input  bptc_ctrl_t         ctrl_i,
  input  bptc_coef_t         coef_i,
  input  logic signed [15:0] raw_temp_i,
  input  logic        [15:0] raw_press_i,
  output logic signed [31:0] press_o
);

  // Stage 1: the four coefficient products with raw temperature.
  logic signed [31:0] sq_prod, oq_prod, ol_prod;
  logic signed [32:0] sl_prod;
  logic signed [16:0] sqt_q, oqt_q;
  logic signed [15:0] slt1_q;
  logic signed [28:0] olt1_q;
  logic signed [15:0] t1_q;
  logic        [15:0] p1_q;
  assign sq_prod = coef_i.s_square * raw_temp_i;
  assign oq_prod = coef_i.o_square * raw_temp_i;
  assign ol_prod = coef_i.o_linear * raw_temp_i;
  assign sl_prod = $signed({1'b0, coef_i.s_linear}) * raw_temp_i;

  // Stage 2: second multiplication of the quadratic terms.
  logic signed [32:0] sq2_prod, oq2_prod;
  logic signed [13:0] sq2_q;
  logic signed [28:0] oq2_q;
  logic signed [15:0] slt2_q;
  logic signed [28:0] olt2_q;
  logic        [15:0] p2_q;
  assign sq2_prod = sqt_q * t1_q;
  assign oq2_prod = oqt_q * t1_q;

  // Stage 3: sum sensitivity and offset.
  logic signed [17:0] s_sum;
  logic signed [31:0] o_sum;
  logic signed [17:0] s3_q;
  logic signed [31:0] o3_q;
  logic        [15:0] p3_q;
  assign s_sum = 18'(sq2_q) + $signed({2'b0, coef_i.s_const}) + 18'(slt2_q);
  assign o_sum = 32'(oq2_q) + 32'(olt2_q) + (32'(coef_i.o_const) <<< 14);

  // Stage 4: sensitivity times raw pressure, formed wide.
  logic signed [34:0] sp_prod;
  logic signed [34:0] sp4_q;
  logic signed [31:0] o4_q;
  assign sp_prod = 35'(s3_q) * $signed({19'b0, p3_q});

  // Stage 5: add the offset, shift, clamp.
  logic signed [35:0] total;
  logic signed [31:0] p5_q;
  assign total = 36'(sp4_q) + 36'(o4_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      sqt_q  <= sq_prod[31:15];
      oqt_q  <= oq_prod[31:15];
      slt1_q <= sl_prod[32:17];
      olt1_q <= ol_prod[31:3];
      t1_q   <= raw_temp_i;
      p1_q   <= raw_press_i;
    end
    if (ctrl_i.en[1]) begin
      sq2_q  <= sq2_prod[32:19];
      oq2_q  <= oq2_prod[32:4];
      slt2_q <= slt1_q;
      olt2_q <= olt1_q;
      p2_q   <= p1_q;
    end
    if (ctrl_i.en[2]) begin
      s3_q <= s_sum;
      o3_q <= o_sum;
      p3_q <= p2_q;
    end
    if (ctrl_i.en[3]) begin
      sp4_q <= sp_prod;
      o4_q  <= o3_q;
    end
    if (ctrl_i.en[4]) begin
      p5_q <= sat32(total[35:14]);
    end
  end

  assign press_o = p5_q;

endmodule

>>> design/baro_temp_pressure_compensation.sv
// Top level of the barometric temperature and pressure compensation block.
// Depends on bptc_pkg, bptc_cfg_regs, bptc_pipe_ctrl and the two datapaths.
//
// Usage: the eight calibration coefficients are written over the cfg channel
// (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i); the port is always
// ready, and an index above seven is dropped. The user must write coefficients
// only while no reading is in flight; the block itself does not enforce it. Raw
// readings arrive as one transfer on the in channel and each produces exactly
// one transfer on the out channel. An accepted reading passes through the five
// register stages in turn and is then valid on out. Throughput is one reading
// per cycle while the receiver keeps taking results; the five register stages
// are set by the chain of two multiplications in the quadratic terms, the sum,
// the wide sensitivity product and the final add.
// Each stage loads whenever it is empty or its content moves on, so bubbles
// close up and new readings are taken while a finished result waits.
// When the receiver stalls, the result holds in the output register and the
// pipeline fills behind it; in_ready_o falls only when all stages are full.
// Reset clears the valid chain and all coefficients to zero.
module baro_temp_pressure_compensation
  import bptc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CoefW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bptc_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bptc_out_t          out_data_o
);

  bptc_coef_t coef;
  bptc_ctrl_t ctrl;

  bptc_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .coef_o (coef)
  );

  bptc_pipe_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .out_valid_o,
    .out_ready_i,
    .ctrl_o (ctrl)
  );

  // Only bit 0 of the unit field exists, so it selects Fahrenheit directly.
  bptc_temp_path u_temp (
    .clk_i,
    .ctrl_i     (ctrl),
    .coef_i     (coef),
    .raw_temp_i (in_data_i.raw_temp),
    .fahr_i     (in_data_i.want_fahrenheit),
    .temp_o     (out_data_o.temp_hundredths)
  );

  bptc_press_path u_press (
    .clk_i,
    .ctrl_i      (ctrl),
    .coef_i      (coef),
    .raw_temp_i  (in_data_i.raw_temp),
    .raw_press_i (in_data_i.raw_press),
    .press_o     (out_data_o.pressure_pa)
  );

endmodule

>>> tb/sv/tb_baro_temp_pressure_compensation.sv
// Self-checking testbench for baro_temp_pressure_compensation: a directed table, then random
// readings under several coefficient sets, checked against a behavioral compensation model.
// Depends on bptc_pkg and the block's RTL only.
module tb_baro_temp_pressure_compensation
  import bptc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HalfPeriod    = 4;
  localparam int unsigned ResetCycles   = 12;
  localparam int unsigned NumCoefRegs   = 8;
  localparam int unsigned NumPhases     = 7;
  localparam int unsigned PhaseReadings = 200;
  localparam int unsigned HoldAfter     = 700;
  localparam int unsigned HoldCycles    = 80;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned DrainCycles   = 2 * NumStages + 8;
  localparam int unsigned CycleLimit    = 400000;

  // Register indexes past the last coefficient; the block must drop these writes.
  localparam logic [CfgIdxW-1:0] RegBeyondLo = 4'd8;
  localparam logic [CfgIdxW-1:0] RegBeyondHi = 4'd15;

  // Arithmetic constants of the compensation law, kept signed so that every
  // intermediate stays a signed 64-bit quantity.
  localparam longint HundredthScale = 100;
  localparam longint FahrMul        = 9;
  localparam longint FahrDiv        = 5;
  localparam longint FahrBias       = 3200;
  localparam longint OConstScale    = 16384;
  localparam longint PressMax       = 64'sd2147483647;
  localparam longint PressMin       = -64'sd2147483648;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CoefW-1:0]   cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  bptc_in_t           in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  bptc_out_t          out_data_o;

  baro_temp_pressure_compensation DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #(HalfPeriod) clk_i = 1'b1;
    #(HalfPeriod) clk_i = 1'b0;
  end

  // Shadow copy of the calibration registers, updated on every accepted write to one of them.
  logic [CoefW-1:0] cal_regs [NumCoefRegs];

  // Compensated results still owed by the block, oldest first.
  bptc_out_t pending_results [$];

  int unsigned readings_sent    = 0;
  int unsigned results_checked  = 0;
  int unsigned failures         = 0;
  int unsigned full_pipe_cycles = 0;
  int unsigned coef_sets        = 0;
  int unsigned cycles_run       = 0;

  // Directed stimulus table. A row is either a coefficient write or a reading;
  // a reading row carries a typed-in result when "known" is set, otherwise the
  // result comes from the compensation model.
  typedef enum logic {RowCoef, RowReading} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] reg_idx;
    logic [CoefW-1:0]   reg_val;
    bptc_in_t           reading;
    logic               known;
    bptc_out_t          result;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic dir_row_t coef_row(input logic [CfgIdxW-1:0] idx,
                                        input logic [CoefW-1:0] val);
    dir_row_t row;
    row         = '0;
    row.kind    = RowCoef;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic dir_row_t reading_row(input logic [15:0] t, input logic [15:0] p,
                                           input logic fahr, input logic known,
                                           input logic [15:0] temp, input logic [31:0] press);
    dir_row_t row;
    row                         = '0;
    row.kind                    = RowReading;
    row.reading.raw_temp        = t;
    row.reading.raw_press       = p;
    row.reading.want_fahrenheit = fahr;
    row.known                   = known;
    row.result.temp_hundredths  = temp;
    row.result.pressure_pa      = press;
    return row;
  endfunction

  // Behavioral compensation law. All right shifts are arithmetic (floor), the
  // Fahrenheit division truncates toward zero, temperature wraps to 16 bits and
  // pressure saturates to the signed 32-bit range.
  function automatic bptc_out_t compensate(input bptc_in_t rd);
    longint t, p, gain, toff, sc, sl, sq, oc, ol, oq;
    longint temp, sens, offs, press;
    bptc_out_t res;
    t    = $signed(rd.raw_temp);
    p    = rd.raw_press;
    gain = cal_regs[RegTGain];
    toff = cal_regs[RegTOffset];
    sc   = cal_regs[RegSConst];
    sl   = cal_regs[RegSLinear];
    sq   = $signed(cal_regs[RegSSquare]);
    oc   = $signed(cal_regs[RegOConst]);
    ol   = $signed(cal_regs[RegOLinear]);
    oq   = $signed(cal_regs[RegOSquare]);

    temp = ((((gain * t) >>> 8) + toff * 64) * HundredthScale) >>> 16;
    if (rd.want_fahrenheit) begin
      temp = (temp * FahrMul) / FahrDiv + FahrBias;
    end

    sens  = ((((sq * t) >>> 15) * t) >>> 19) + sc + ((sl * t) >>> 17);
    offs  = ((((oq * t) >>> 15) * t) >>> 4) + ((ol * t) >>> 3) + oc * OConstScale;
    press = (sens * p + offs) >>> 14;
    if (press > PressMax) begin
      press = PressMax;
    end else if (press < PressMin) begin
      press = PressMin;
    end

    res.temp_hundredths = temp[15:0];
    res.pressure_pa     = press[31:0];
    return res;
  endfunction

  // One coefficient write. Valid is left high so back-to-back writes need no
  // lowering in between; the caller drops it when the group is done.
  task automatic write_coef(input logic [CfgIdxW-1:0] idx, input logic [CoefW-1:0] val);
    bit took;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      took = cfg_ready_o;
      @(posedge clk_i);
    end while (!took);
    if (idx < NumCoefRegs) begin
      cal_regs[idx] = val;
    end
  endtask

  task automatic load_coefs(input bptc_coef_t cs);
    write_coef(RegTGain,   cs.t_gain);
    write_coef(RegTOffset, cs.t_offset);
    write_coef(RegSConst,  cs.s_const);
    write_coef(RegSLinear, cs.s_linear);
    write_coef(RegSSquare, cs.s_square);
    write_coef(RegOConst,  cs.o_const);
    write_coef(RegOLinear, cs.o_linear);
    write_coef(RegOSquare, cs.o_square);
    cfg_valid_i <= 1'b0;
    coef_sets++;
  endtask

  // Offer one reading and hold it until the transfer completes. The handshake
  // is sampled at the falling edge, where everything driven at the rising edge
  // has settled, and takes effect at the rising edge that follows.
  task automatic send_reading(input bptc_in_t rd, input bit known, input bptc_out_t typed);
    bit took;
    in_valid_i <= 1'b1;
    in_data_i  <= rd;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    pending_results.push_back(known ? typed : compensate(rd));
    readings_sent++;
  endtask

  // Every reading yields a result, so an empty queue means the block is idle.
  task automatic wait_drained();
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Field values biased toward the corners now and then.
  function automatic logic [15:0] pick_field();
    if ($urandom_range(0, 7) != 0) begin
      return 16'($urandom);
    end
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'hFFFF;
      2:       return 16'h0000;
      3:       return 16'h0001;
      default: return 16'h7FFF;
    endcase
  endfunction

  task automatic check_result(input bptc_out_t got);
    bptc_out_t want;
    if (pending_results.size() == 0) begin
      failures++;
      if (failures <= MaxReports) begin
        $display("Unexpected result: temp %0d pressure %0d",
                 got.temp_hundredths, got.pressure_pa);
      end
    end else begin
      want = pending_results.pop_front();
      if (got.temp_hundredths !== want.temp_hundredths ||
          got.pressure_pa !== want.pressure_pa) begin
        failures++;
        if (failures <= MaxReports) begin
          $display("Mismatch on result %0d: temp exp %0d got %0d, pressure exp %0d got %0d",
                   results_checked, want.temp_hundredths, got.temp_hundredths,
                   want.pressure_pa, got.pressure_pa);
        end
      end
      results_checked++;
    end
  endtask

  // Output monitor. A result counts as transferred when valid and ready are
  // both high in the middle of the cycle; it is checked there.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_ready_o) begin
        full_pipe_cycles++;
      end
      if (out_valid_o && out_ready_i) begin
        check_result(out_data_o);
      end
    end
  end

  // Receiver: segments of always-ready, coin-flip and mostly-stalled behavior.
  // Once, well into the random part, it holds off for a long stretch so that
  // the pipeline fills up and the block has to push back on its input.
  initial begin : receiver
    int unsigned seg_len;
    int unsigned mode;
    bit          held;
    held        = 1'b0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!held && readings_sent >= HoldAfter) begin
        held = 1'b1;
        for (int i = 0; i < HoldCycles; i++) begin
          @(posedge clk_i);
          out_ready_i <= 1'b0;
        end
      end
      mode    = $urandom_range(0, 2);
      seg_len = $urandom_range(8, 120);
      for (int i = 0; i < seg_len; i++) begin
        @(posedge clk_i);
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Cycle budget for the whole run; a correct run stays far below it.
  initial begin : watchdog
    while (cycles_run < CycleLimit) begin
      @(posedge clk_i);
      cycles_run++;
    end
    $display("[baro_temp_pressure_compensation] ERROR");
    $finish;
  end

  initial begin : stimulus
    bptc_in_t    rd;
    bptc_coef_t  cs;
    int unsigned burst;
    bit          hi_u;
    bit          hi_s;

    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    foreach (cal_regs[i]) begin
      cal_regs[i] = '0;
    end

    // With all coefficients at reset the law collapses: Celsius is zero,
    // Fahrenheit is the bare offset, and pressure is zero.
    dir_rows.push_back(reading_row(16'h0000, 16'h0000, 1'b0, 1'b1, 16'd0,    32'd0));
    dir_rows.push_back(reading_row(16'h8000, 16'hFFFF, 1'b1, 1'b1, 16'd3200, 32'd0));
    dir_rows.push_back(reading_row(16'h7FFF, 16'hFFFF, 1'b0, 1'b1, 16'd0,    32'd0));
    dir_rows.push_back(reading_row(16'hFFFF, 16'h0001, 1'b1, 1'b1, 16'd3200, 32'd0));
    // Writes past the last register must leave the coefficients untouched.
    dir_rows.push_back(coef_row(RegBeyondLo, 16'hFFFF));
    dir_rows.push_back(coef_row(RegBeyondHi, 16'h5555));
    dir_rows.push_back(reading_row(16'h7FFF, 16'hFFFF, 1'b1, 1'b1, 16'd3200, 32'd0));
    // Every coefficient at its positive extreme; hot Fahrenheit wraps 16 bits.
    dir_rows.push_back(coef_row(RegTGain,   16'hFFFF));
    dir_rows.push_back(coef_row(RegTOffset, 16'hFFFF));
    dir_rows.push_back(coef_row(RegSConst,  16'hFFFF));
    dir_rows.push_back(coef_row(RegSLinear, 16'hFFFF));
    dir_rows.push_back(coef_row(RegSSquare, 16'h7FFF));
    dir_rows.push_back(coef_row(RegOConst,  16'h7FFF));
    dir_rows.push_back(coef_row(RegOLinear, 16'h7FFF));
    dir_rows.push_back(coef_row(RegOSquare, 16'h7FFF));
    dir_rows.push_back(reading_row(16'h7FFF, 16'hFFFF, 1'b1, 1'b0, '0, '0));
    dir_rows.push_back(reading_row(16'h7FFF, 16'hFFFF, 1'b0, 1'b0, '0, '0));
    dir_rows.push_back(reading_row(16'h8000, 16'h0000, 1'b0, 1'b0, '0, '0));
    dir_rows.push_back(reading_row(16'h8000, 16'hFFFF, 1'b1, 1'b0, '0, '0));
    dir_rows.push_back(reading_row(16'h0000, 16'h0000, 1'b0, 1'b0, '0, '0));
    dir_rows.push_back(reading_row(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, '0, '0));
    // Signed terms at their negative extreme, no offset: deep negative
    // temperatures and the most negative pressure the law can reach.
    dir_rows.push_back(coef_row(RegTOffset, 16'h0000));
    dir_rows.push_back(coef_row(RegSConst,  16'h0000));
    dir_rows.push_back(coef_row(RegSSquare, 16'h8000));
    dir_rows.push_back(coef_row(RegOConst,  16'h8000));
    dir_rows.push_back(coef_row(RegOLinear, 16'h8000));
    dir_rows.push_back(coef_row(RegOSquare, 16'h8000));
    dir_rows.push_back(reading_row(16'h8000, 16'hFFFF, 1'b1, 1'b0, '0, '0));
    dir_rows.push_back(reading_row(16'h8000, 16'hFFFF, 1'b0, 1'b0, '0, '0));
    dir_rows.push_back(reading_row(16'h7FFF, 16'hFFFF, 1'b0, 1'b0, '0, '0));
    dir_rows.push_back(reading_row(16'h7FFF, 16'h0000, 1'b1, 1'b0, '0, '0));
    dir_rows.push_back(reading_row(16'h0001, 16'h0001, 1'b0, 1'b0, '0, '0));

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: coefficient writes only once every result is back.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowCoef) begin
        in_valid_i <= 1'b0;
        wait_drained();
        write_coef(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        cfg_valid_i <= 1'b0;
        send_reading(dir_rows[i].reading, dir_rows[i].known, dir_rows[i].result);
      end
    end

    // Random part. The first four coefficient sets combine the unsigned and
    // signed extremes; the rest are fully random. Readings go out in bursts
    // of random length separated by short gaps.
    for (int ph = 0; ph < NumPhases; ph++) begin
      in_valid_i <= 1'b0;
      wait_drained();
      if (ph < 4) begin
        hi_u        = (ph == 0 || ph == 2);
        hi_s        = (ph == 0 || ph == 3);
        cs.t_gain   = hi_u ? 16'hFFFF : 16'h0000;
        cs.t_offset = hi_u ? 16'hFFFF : 16'h0000;
        cs.s_const  = hi_u ? 16'hFFFF : 16'h0000;
        cs.s_linear = hi_u ? 16'hFFFF : 16'h0000;
        cs.s_square = hi_s ? 16'h7FFF : 16'h8000;
        cs.o_const  = hi_s ? 16'h7FFF : 16'h8000;
        cs.o_linear = hi_s ? 16'h7FFF : 16'h8000;
        cs.o_square = hi_s ? 16'h7FFF : 16'h8000;
      end else begin
        cs = {$urandom, $urandom, $urandom, $urandom};
      end
      load_coefs(cs);

      burst = $urandom_range(1, 60);
      for (int n = 0; n < PhaseReadings; n++) begin
        rd.raw_temp        = pick_field();
        rd.raw_press       = pick_field();
        rd.want_fahrenheit = 1'($urandom_range(0, 1));
        send_reading(rd, 1'b0, '0);
        burst--;
        if (burst == 0) begin
          // The gap waits on the clock before the next reading, so valid never drops and rises
          // again within the same edge.
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
          burst = $urandom_range(1, 60);
        end
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    // Give a stray extra result time to show up before judging.
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d readings (%0d checked) over %0d coefficient sets;",
             readings_sent, results_checked, coef_sets);
    $display("input held off %0d cycles.", full_pipe_cycles);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("[baro_temp_pressure_compensation] OK");
    end else begin
      $display("[baro_temp_pressure_compensation] ERROR");
    end
    $finish;
  end

endmodule
